[sv/cddc_pkg.sv]
// ----------------------------------------------------------------------------
// cddc_pkg: shared types and constants for the date / day count converter
// Holds the sequencer states, field widths and the cumulative month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cddc_pkg;

  localparam int CNT_W   = 16;  // day count and accumulator width
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;   // day-of-year offsets, below 366

  localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd2000;
  localparam logic [CNT_W-1:0]   DAYS_NORMAL = 16'd365;
  localparam logic [CNT_W-1:0]   DAYS_LEAP   = 16'd366;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd11;   // zero-based December

  typedef logic [DOY_W-1:0] month_tab_t [12];

  localparam month_tab_t MS_NORMAL = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam month_tab_t MS_LEAP = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_ADD,
    ST_MONTH,
    ST_DAY,
    ST_FINISH
  } st_t;

  // first day-of-year of a zero-based month; codes past December read as zero
  function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] v;
    v = '0;
    if (idx <= LAST_MONTH) begin
      v = leap ? MS_LEAP[idx] : MS_NORMAL[idx];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/cddc_alu.sv]
// ----------------------------------------------------------------------------
// cddc_alu: shared add / subtract unit
// One adder used by every sequencer step; reports borrow on subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module cddc_alu (
  input  wire logic [cddc_pkg::CNT_W-1:0] a,
  input  wire logic [cddc_pkg::CNT_W-1:0] b,
  input  wire logic                       sub,
  output logic      [cddc_pkg::CNT_W-1:0] res,
  output logic                            borrow
);
  import cddc_pkg::*;

  logic [CNT_W:0] sum;

  always_comb begin
    if (sub) begin
      sum = {1'b0, a} - {1'b0, b};
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
  end

  assign res    = sum[CNT_W-1:0];
  assign borrow = sub & sum[CNT_W];

endmodule

`default_nettype wire

[sv/calendar_date_day_count_converter_core.sv]
// ----------------------------------------------------------------------------
// calendar_date_day_count_converter_core: date <-> day count since 2000-01-01
//
//   channel | tdata (low bit up)                     | tuser
//   in_     | in_year, in_month, in_day, in_count    | op
//   out_    | out_count, out_year, out_month, out_day| range_error
//
// One transaction at a time through a single shared adder. Date to count
// walks the years before the target (one year length per cycle), then adds
// the day of year; count to date strips whole years the same way, then runs
// the 11-step month table search. Rejected inputs go straight to finish.
// Reset empties the sequencer and the output register. A stalled result
// holds in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_day_count_converter_core #(
  parameter int YEAR_SPAN = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // in_year[11:0], in_month[15:12], in_day[20:16],
                                       // in_count[36:21], zero fill
  input  wire logic        in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // out_count[15:0], out_year[27:16], out_month[31:28],
                                       // out_day[36:32], zero fill
  output logic             out_tuser   // range_error
);
  import cddc_pkg::*;

  localparam int YC_RAW     = $clog2(YEAR_SPAN + 1);
  localparam int YC_W       = (YC_RAW < 2) ? 2 : YC_RAW;
  localparam int LAST_COUNT = 365 * YEAR_SPAN + (YEAR_SPAN + 3) / 4 - 1;
  localparam int YEAR_END   = 2000 + YEAR_SPAN;

  // input unpack
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic [CNT_W-1:0]   in_count;
  logic               in_op;

  assign in_year  = in_tdata[11:0];
  assign in_month = in_tdata[15:12];
  assign in_day   = in_tdata[20:16];
  assign in_count = in_tdata[36:21];
  assign in_op    = in_tuser;

  st_t                state_r, state_nxt;
  logic               op_r, op_nxt;
  logic               err_r, err_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [YC_W-1:0]    yr_r, yr_nxt;
  logic [YC_W-1:0]    ytgt_r, ytgt_nxt;
  logic [MONTH_W-1:0] mon_r, mon_nxt;
  logic [MONTH_W-1:0] idx_r, idx_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [39:0]        out_tdata_r, out_tdata_nxt;
  logic               out_tuser_r, out_tuser_nxt;

  logic [CNT_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_sub, alu_borrow;

  cddc_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  logic               leap;
  logic [CNT_W-1:0]   year_len;
  logic [YC_W:0]      yr_inc;
  logic               more_years;
  logic [YEAR_W:0]    yoff;
  logic               year_ok;
  logic               date_ok;
  logic               count_ok;

  assign leap       = (yr_r[1:0] == 2'd0);
  assign year_len   = leap ? DAYS_LEAP : DAYS_NORMAL;
  assign yr_inc     = {1'b0, yr_r} + {{YC_W{1'b0}}, 1'b1};
  assign more_years = (yr_inc < (YC_W+1)'(YEAR_SPAN));
  assign yoff       = {1'b0, in_year} - {1'b0, BASE_YEAR};
  assign year_ok    = (in_year >= BASE_YEAR) &&
                      ({1'b0, in_year} < (YEAR_W+1)'(YEAR_END));
  assign date_ok    = year_ok && (in_month != '0) && (in_month <= 4'd12) && (in_day != '0);
  assign count_ok   = ({1'b0, in_count} <= (CNT_W+1)'(LAST_COUNT));

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    err_nxt        = err_r;
    acc_nxt        = acc_r;
    yr_nxt         = yr_r;
    ytgt_nxt       = ytgt_r;
    mon_nxt        = mon_r;
    idx_nxt        = idx_r;
    day_nxt        = day_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    alu_a          = acc_r;
    alu_b          = year_len;
    alu_sub        = op_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_op;
          yr_nxt   = '0;
          ytgt_nxt = yoff[YC_W-1:0];
          mon_nxt  = in_month - 4'd1;
          day_nxt  = in_day;
          acc_nxt  = in_op ? in_count : '0;
          err_nxt  = in_op ? !count_ok : !date_ok;
          state_nxt = (in_op ? !count_ok : !date_ok) ? ST_FINISH : ST_YEAR;
        end
      end
      ST_YEAR: begin
        alu_a = acc_r;
        alu_b = year_len;
        if (!op_r) begin
          // sum the lengths of the years before the target
          alu_sub = 1'b0;
          if (yr_r != ytgt_r) begin
            acc_nxt = alu_res;
            yr_nxt  = yr_inc[YC_W-1:0];
          end else begin
            state_nxt = ST_ADD;
          end
        end else begin
          // strip whole years while the remainder covers one
          alu_sub = 1'b1;
          if (!alu_borrow && more_years) begin
            acc_nxt = alu_res;
            yr_nxt  = yr_inc[YC_W-1:0];
          end else begin
            mon_nxt   = '0;
            idx_nxt   = 4'd1;
            state_nxt = ST_MONTH;
          end
        end
      end
      ST_ADD: begin
        alu_sub = 1'b0;
        alu_b   = CNT_W'(month_start(leap, mon_r)) + CNT_W'(day_r) - CNT_W'(1);
        acc_nxt = alu_res;
        state_nxt = ST_FINISH;
      end
      ST_MONTH: begin
        alu_sub = 1'b1;
        alu_b   = CNT_W'(month_start(leap, idx_r));
        if (!alu_borrow) begin
          mon_nxt = idx_r;
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == LAST_MONTH) begin
          state_nxt = ST_DAY;
        end
      end
      ST_DAY: begin
        alu_sub = 1'b1;
        alu_b   = CNT_W'(month_start(leap, mon_r));
        day_nxt = alu_res[DAY_W-1:0] + DAY_W'(1);
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = err_r;
          out_tdata_nxt  = '0;
          if (!err_r) begin
            if (!op_r) begin
              out_tdata_nxt[15:0] = acc_r;
            end else begin
              out_tdata_nxt[27:16] = BASE_YEAR + YEAR_W'(yr_r);
              out_tdata_nxt[31:28] = mon_r + 4'd1;
              out_tdata_nxt[36:32] = day_r;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    err_r       <= err_nxt;
    acc_r       <= acc_nxt;
    yr_r        <= yr_nxt;
    ytgt_r      <= ytgt_nxt;
    mon_r       <= mon_nxt;
    idx_r       <= idx_nxt;
    day_r       <= day_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a taken transaction closes the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after accepting a transaction");

  // month search runs over table entries one through eleven only
  a_month_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MONTH |-> (idx_r >= 4'd1) && (idx_r <= LAST_MONTH))
    else $error("month search index out of range");

  // forward year walk never passes its target
  a_year_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_YEAR && !op_r |-> yr_r <= ytgt_r)
    else $error("year walk passed the target year");

  // year walk stays inside the supported span
  a_year_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_YEAR |-> {1'b0, yr_r} < (YC_W+1)'(YEAR_SPAN))
    else $error("year counter left the supported span");

endmodule

`default_nettype wire

[tb/cddc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// cddc_tb_pkg: testbench types for the date / day count converter
// Direction codes carried on in_tuser and the layout of one predicted result.
// ----------------------------------------------------------------------------
package cddc_tb_pkg;

  import cddc_pkg::*;

  typedef enum logic {
    OP_DATE_TO_COUNT = 1'b0,
    OP_COUNT_TO_DATE = 1'b1
  } conv_op_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               range_error;
  } conversion_t;

endpackage

[tb/cddc_result_checker.sv]
// ----------------------------------------------------------------------------
// cddc_result_checker: prediction and comparison for the converter
// Watches both stream channels, predicts the conversion of every accepted
// input transaction and compares each accepted result against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module cddc_result_checker
  import cddc_pkg::*;
  import cddc_tb_pkg::*;
#(
  parameter int YEAR_SPAN = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  output int          mismatches,
  output int          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  conversion_t expected_conversions[$];

  // Day count of January 1st, relative year rel; years 0, 4, 8, ... are leap.
  function automatic int unsigned year_first_day(input int unsigned rel);
    return 365 * rel + (rel + 3) / 4;
  endfunction

  function automatic int unsigned days_before_month(input logic leap, input int unsigned mon);
    int unsigned sum;
    sum = 0;
    for (int unsigned m = 1; m < mon; m++) begin
      if (m == 2) begin
        sum += leap ? 29 : 28;
      end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
        sum += 30;
      end else begin
        sum += 31;
      end
    end
    return sum;
  endfunction

  function automatic conversion_t convert_date_count(input conv_op_t op,
                                                     input logic [YEAR_W-1:0] yr,
                                                     input logic [MONTH_W-1:0] mo,
                                                     input logic [DAY_W-1:0] dy,
                                                     input logic [CNT_W-1:0] cnt);
    conversion_t r;
    int unsigned rel, doy, mon, total;
    logic leap;
    r = '0;
    if (op == OP_DATE_TO_COUNT) begin
      if (yr < 2000 || yr >= 2000 + YEAR_SPAN || mo < 1 || mo > 12 || dy < 1) begin
        r.range_error = 1'b1;
      end else begin
        rel = yr - 2000;
        leap = (rel % 4 == 0);
        // no check against the month length: Feb 31 runs on into March
        total = year_first_day(rel) + days_before_month(leap, mo) + dy - 1;
        r.count = total[CNT_W-1:0];
      end
    end else begin
      if (cnt > year_first_day(YEAR_SPAN) - 1) begin
        r.range_error = 1'b1;
      end else begin
        rel = 0;
        while (rel + 1 < YEAR_SPAN && year_first_day(rel + 1) <= cnt) rel++;
        leap = (rel % 4 == 0);
        doy = cnt - year_first_day(rel);
        mon = 1;
        while (mon < 12 && days_before_month(leap, mon + 1) <= doy) mon++;
        r.year  = YEAR_W'(2000 + rel);
        r.month = MONTH_W'(mon);
        r.day   = DAY_W'(doy - days_before_month(leap, mon) + 1);
      end
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    conversion_t want;
    conversion_t pred;
    logic [CNT_W-1:0]   got_count;
    logic [YEAR_W-1:0]  got_year;
    logic [MONTH_W-1:0] got_month;
    logic [DAY_W-1:0]   got_day;
    int fails;
    fails = 0;
    if (rst_n) begin
      // retire the result before adding a prediction: a result never leaves in the
      // same cycle its input is taken
      if (out_tvalid && out_tready) begin
        got_count = out_tdata[15:0];
        got_year  = out_tdata[27:16];
        got_month = out_tdata[31:28];
        got_day   = out_tdata[36:32];
        if (expected_conversions.size() == 0) begin
          $error("result transaction with no prediction waiting: tdata=%h tuser=%b",
                 out_tdata, out_tuser);
          fails++;
        end else begin
          want = expected_conversions.pop_front();
          if (got_count !== want.count) begin
            $error("out_count: expected %0d, got %0d", want.count, got_count);
            fails++;
          end
          if (got_year !== want.year) begin
            $error("out_year: expected %0d, got %0d", want.year, got_year);
            fails++;
          end
          if (got_month !== want.month) begin
            $error("out_month: expected %0d, got %0d", want.month, got_month);
            fails++;
          end
          if (got_day !== want.day) begin
            $error("out_day: expected %0d, got %0d", want.day, got_day);
            fails++;
          end
          if (out_tuser !== want.range_error) begin
            $error("range_error: expected %0b, got %0b", want.range_error, out_tuser);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pred = convert_date_count(conv_op_t'(in_tuser), in_tdata[11:0], in_tdata[15:12],
                                  in_tdata[20:16], in_tdata[36:21]);
        expected_conversions.insert(expected_conversions.size(), pred);
      end
    end
    mismatches <= mismatches + fails;
    outstanding <= expected_conversions.size();
  end

  final begin
    if (expected_conversions.size() != 0) begin
      $error("%0d predicted results never arrived", expected_conversions.size());
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for calendar_date_day_count_converter_core
// Drives directed edge dates and counts, then random well-formed and malformed
// conversions in both directions with random gaps and stalls on both channels,
// including a long result stall and a full drain mid-run.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import cddc_pkg::*;
  import cddc_tb_pkg::*;

  localparam int SPAN         = 128;
  localparam int RANDOM_ITEMS = 1030;
  localparam int LAST_COUNT   = 46751;
  localparam int TAIL_CYCLES  = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // in_year, in_month, in_day, in_count, zero fill
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // out_count, out_year, out_month, out_day, zero fill
  logic        out_tuser;       // range_error
  int          mismatches;
  int          outstanding;
  logic        sender_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_day_count_converter_core #(.YEAR_SPAN(SPAN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  cddc_result_checker #(.YEAR_SPAN(SPAN)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  task automatic offer_conversion(input conv_op_t op, input logic [YEAR_W-1:0] yr,
                                  input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
                                  input logic [CNT_W-1:0] cnt);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, cnt, dy, mo, yr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Feed dates with random counts riding along, counts with random dates riding along.
  task automatic offer_date(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
                            input logic [DAY_W-1:0] dy);
    offer_conversion(OP_DATE_TO_COUNT, yr, mo, dy, CNT_W'($urandom));
  endtask

  task automatic offer_count(input logic [CNT_W-1:0] cnt);
    logic [31:0] junk;
    junk = $urandom;
    offer_conversion(OP_COUNT_TO_DATE, junk[11:0], junk[15:12], junk[20:16], cnt);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: random backpressure, calm stretches, and one long hold-off.
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ((taken / 80) % 2 == 1) ? 0 : $urandom_range(0, 9);
      if (taken == 300) begin
        gap = 400;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int sel;
    int rel;
    logic [31:0] junk;
    logic [31:0] edge_count;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dates: span ends, leap day, overflow into next month, rejects
    offer_date(12'd2000, 4'd1, 5'd1);
    offer_date(12'd2127, 4'd12, 5'd31);
    offer_date(12'd2000, 4'd2, 5'd29);
    offer_date(12'd2001, 4'd2, 5'd31);
    offer_date(12'd2004, 4'd12, 5'd31);
    offer_date(12'd2127, 4'd0, 5'd10);
    offer_date(12'd2050, 4'd13, 5'd10);
    offer_date(12'd2050, 4'd15, 5'd31);
    offer_date(12'd2050, 4'd6, 5'd0);
    offer_date(12'd1999, 4'd12, 5'd31);
    offer_date(12'd2128, 4'd1, 5'd1);
    offer_date(12'd4095, 4'd1, 5'd1);
    offer_date(12'd0, 4'd1, 5'd1);
    // counts: span ends, year and leap boundaries, too large
    offer_count(16'd0);
    offer_count(16'd59);
    offer_count(16'd60);
    offer_count(16'd365);
    offer_count(16'd366);
    offer_count(16'd1460);
    offer_count(16'd1461);
    offer_count(CNT_W'(LAST_COUNT));
    offer_count(CNT_W'(LAST_COUNT + 1));
    offer_count(16'hFFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_calm = ((i / 100) % 3 == 2);
      if (i == 500) begin
        drain_results();
      end
      sel = $urandom_range(0, 9);
      junk = $urandom;
      if (sel < 4) begin
        offer_date(YEAR_W'(2000 + $urandom_range(0, SPAN - 1)),
                   MONTH_W'($urandom_range(1, 12)),
                   DAY_W'($urandom_range(1, 31)));
      end else if (sel < 6) begin
        offer_count(CNT_W'($urandom_range(0, LAST_COUNT)));
      end else if (sel < 8) begin
        // land on or just before a January 1st
        rel = $urandom_range(0, SPAN);
        edge_count = 365 * rel + (rel + 3) / 4 - $urandom_range(0, 1);
        offer_count(edge_count[15:0]);
      end else begin
        offer_conversion(conv_op_t'(junk[0]), junk[12:1], junk[16:13], junk[21:17],
                         CNT_W'($urandom));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
